/* src/vector_matrix_transform_4x4_core_assert.svh */
// Assertion macros for the 4x4 vector-matrix transform core.
// Used by the top level; relies on clk and rst_n being in scope.
`ifndef VECTOR_MATRIX_TRANSFORM_4X4_CORE_ASSERT_SVH
`define VECTOR_MATRIX_TRANSFORM_4X4_CORE_ASSERT_SVH

// Implication checked on every rising edge outside reset.
`define VMT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence checked in the cycle after the antecedent.
`define VMT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/vmt_pkg.sv */
// Shared types and constants of the 4x4 vector-matrix transform core.
// No dependencies; imported by every module of the block.
package vmt_pkg;

    localparam int NUM_ROWS   = 4;
    localparam int NUM_COLS   = 4;
    localparam int COMP_W     = 32;
    localparam int COEF_W     = 16;
    localparam int ROW_W      = NUM_COLS * COEF_W;
    localparam int PROD_W     = COMP_W + COEF_W;
    localparam int PAIR_W     = PROD_W + 1;
    localparam int SUM_W      = PROD_W + 2;
    localparam int FRAC_SHIFT = 12;
    localparam int SHIFT_W    = SUM_W - FRAC_SHIFT;
    localparam int INDEX_W    = 2;

    // Register indexes of the configuration port.
    localparam logic [INDEX_W-1:0] REG_MATRIX_ROW_0 = 2'd0;
    localparam logic [INDEX_W-1:0] REG_MATRIX_ROW_1 = 2'd1;
    localparam logic [INDEX_W-1:0] REG_MATRIX_ROW_2 = 2'd2;
    localparam logic [INDEX_W-1:0] REG_MATRIX_ROW_3 = 2'd3;

    // Identity matrix, one Q4.12 one on the diagonal.
    localparam logic [ROW_W-1:0] ROW_0_RESET = 64'h0000_0000_0000_1000;
    localparam logic [ROW_W-1:0] ROW_1_RESET = 64'h0000_0000_1000_0000;
    localparam logic [ROW_W-1:0] ROW_2_RESET = 64'h0000_1000_0000_0000;
    localparam logic [ROW_W-1:0] ROW_3_RESET = 64'h1000_0000_0000_0000;

    localparam logic [COMP_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [COMP_W-1:0] SAT_MIN = 32'h8000_0000;

    typedef logic [NUM_ROWS-1:0][COMP_W-1:0] vec_t;
    typedef logic [NUM_ROWS-1:0][COEF_W-1:0] coef_col_t;
    typedef logic [NUM_COLS-1:0][SUM_W-1:0]  lane_sums_t;

    // Stage enables of the lane pipeline.
    typedef struct packed {
        logic en_mul;
        logic en_pair;
        logic en_sum;
    } pipe_ctrl_t;

endpackage

/* src/vmt_lane.sv */
// One output column: four products, a pair-sum stage and a final sum.
// Depends on vmt_pkg.
module vmt_lane (
    input  logic                         clk,
    input  vmt_pkg::pipe_ctrl_t          ctrl,
    input  vmt_pkg::vec_t                vec,
    input  vmt_pkg::coef_col_t           coef,
    output logic signed [vmt_pkg::SUM_W-1:0] sum
);
    import vmt_pkg::*;

    logic signed [PROD_W-1:0] prod_reg [NUM_ROWS];
    logic signed [PAIR_W-1:0] pair_reg [2];
    logic signed [SUM_W-1:0]  sum_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.en_mul)
        begin
            for (int r = 0; r < NUM_ROWS; r++)
            begin
                prod_reg[r] <= PROD_W'($signed(vec[r])) * PROD_W'($signed(coef[r]));
            end
        end
        if (ctrl.en_pair)
        begin
            pair_reg[0] <= PAIR_W'(prod_reg[0]) + PAIR_W'(prod_reg[1]);
            pair_reg[1] <= PAIR_W'(prod_reg[2]) + PAIR_W'(prod_reg[3]);
        end
        if (ctrl.en_sum)
        begin
            sum_reg <= SUM_W'(pair_reg[0]) + SUM_W'(pair_reg[1]);
        end
    end

    assign sum = sum_reg;

endmodule

/* src/vmt_merge.sv */
// Merging stage: floor shift and saturation of each lane sum, flag OR,
// and the output register. Depends on vmt_pkg.
module vmt_merge (
    input  logic                   clk,
    input  logic                   load,
    input  vmt_pkg::lane_sums_t    sums,
    output vmt_pkg::vec_t          result,
    output logic                   saturated
);
    import vmt_pkg::*;

    vec_t                      result_next;
    logic [NUM_COLS-1:0]       clamp;
    vec_t                      result_reg;
    logic                      saturated_reg;

    always_comb
    begin
        logic signed [SHIFT_W-1:0] q;
        for (int c = 0; c < NUM_COLS; c++)
        begin
            // Arithmetic shift gives the floor for negative sums.
            q = SHIFT_W'($signed(sums[c]) >>> FRAC_SHIFT);
            // The value fits when every bit above bit 31 equals the sign.
            clamp[c] = (q[SHIFT_W-1:COMP_W-1] != {(SHIFT_W-COMP_W+1){1'b0}}) &&
                       (q[SHIFT_W-1:COMP_W-1] != {(SHIFT_W-COMP_W+1){1'b1}});
            if (!clamp[c])
            begin
                result_next[c] = q[COMP_W-1:0];
            end
            else if (q[SHIFT_W-1])
            begin
                result_next[c] = SAT_MIN;
            end
            else
            begin
                result_next[c] = SAT_MAX;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg    <= result_next;
            saturated_reg <= |clamp;
        end
    end

    assign result    = result_reg;
    assign saturated = saturated_reg;

endmodule

/* src/vector_matrix_transform_4x4_core.sv */
// Channel   | Direction | Payload
// s_axis    | in        | tdata: in_x, in_y, in_z, in_w (32 bits each, x lowest)
// m_axis    | out       | tdata: out_x, out_y, out_z, out_w; tuser: saturated
// config    | in        | wr_en, wr_index (0..3 = matrix_row_0..3), wr_data 64 bits
//
// One beat is accepted per clock unless an output stall holds the pipeline; each result
// passes the multiply, pair-sum, final-sum and saturation/output registers in turn.
// Reset is asynchronous and loads the identity matrix; no clearing pass.
// A stall on the output holds only the stages behind a waiting result, so
// empty stages keep filling while the output register is occupied.
//
// Top level of the transform; depends on vmt_pkg, vmt_lane, vmt_merge and
// vector_matrix_transform_4x4_core_assert.svh.
`include "vector_matrix_transform_4x4_core_assert.svh"

module vector_matrix_transform_4x4_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [127:0]                  s_tdata,   // in_x, in_y, in_z, in_w
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [127:0]                  m_tdata,   // out_x, out_y, out_z, out_w
    output logic [0:0]                    m_tuser,   // saturated
    input  logic                          wr_en,
    input  logic [vmt_pkg::INDEX_W-1:0]   wr_index,
    input  logic [vmt_pkg::ROW_W-1:0]     wr_data
);
    import vmt_pkg::*;

    logic [ROW_W-1:0] row_reg [NUM_ROWS];
    logic             mul_valid_reg;
    logic             pair_valid_reg;
    logic             sum_valid_reg;
    logic             out_valid_reg;

    logic             en_out;
    pipe_ctrl_t       ctrl;
    vec_t             vec;
    lane_sums_t       sums;
    vec_t             result;
    logic             saturated;
    logic             clamp_seen;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0] <= ROW_0_RESET;
            row_reg[1] <= ROW_1_RESET;
            row_reg[2] <= ROW_2_RESET;
            row_reg[3] <= ROW_3_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_MATRIX_ROW_0: row_reg[0] <= wr_data;
                REG_MATRIX_ROW_1: row_reg[1] <= wr_data;
                REG_MATRIX_ROW_2: row_reg[2] <= wr_data;
                REG_MATRIX_ROW_3: row_reg[3] <= wr_data;
                default:          row_reg[0] <= row_reg[0];
            endcase
        end
    end

    // A stage advances when it is empty or the stage after it advances.
    assign en_out       = !out_valid_reg || m_tready;
    assign ctrl.en_sum  = !sum_valid_reg || en_out;
    assign ctrl.en_pair = !pair_valid_reg || ctrl.en_sum;
    assign ctrl.en_mul  = !mul_valid_reg || ctrl.en_pair;
    assign s_tready     = ctrl.en_mul;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg  <= 1'b0;
            pair_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (ctrl.en_mul)
            begin
                mul_valid_reg <= s_tvalid;
            end
            if (ctrl.en_pair)
            begin
                pair_valid_reg <= mul_valid_reg;
            end
            if (ctrl.en_sum)
            begin
                sum_valid_reg <= pair_valid_reg;
            end
            if (en_out)
            begin
                out_valid_reg <= sum_valid_reg;
            end
        end
    end

    assign vec = s_tdata;

    for (genvar c = 0; c < NUM_COLS; c++)
    begin : g_lane
        coef_col_t coef;
        for (genvar r = 0; r < NUM_ROWS; r++)
        begin : g_coef
            assign coef[r] = row_reg[r][c*COEF_W +: COEF_W];
        end
        vmt_lane u_lane (
            .clk  (clk),
            .ctrl (ctrl),
            .vec  (vec),
            .coef (coef),
            .sum  (sums[c])
        );
    end

    vmt_merge u_merge (
        .clk       (clk),
        .load      (en_out),
        .sums      (sums),
        .result    (result),
        .saturated (saturated)
    );

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = result;
    assign m_tuser[0] = saturated;

    // Some component of the output beat sits on one of the two rails.
    assign clamp_seen = (m_tdata[31:0] == SAT_MAX) || (m_tdata[31:0] == SAT_MIN) ||
                        (m_tdata[63:32] == SAT_MAX) || (m_tdata[63:32] == SAT_MIN) ||
                        (m_tdata[95:64] == SAT_MAX) || (m_tdata[95:64] == SAT_MIN) ||
                        (m_tdata[127:96] == SAT_MAX) || (m_tdata[127:96] == SAT_MIN);

    `VMT_ASSERT_IMP(a_ready_when_out_empty, !m_tvalid, s_tready, "input stalled with output empty")
    `VMT_ASSERT_NEXT(a_beat_enters_pipe, s_tvalid && s_tready, mul_valid_reg, "accepted beat lost")
    `VMT_ASSERT_IMP(a_sat_has_clamp, m_tvalid && m_tuser[0], clamp_seen, "flag without a clamp")

endmodule

/* test/vector_matrix_transform_4x4_core_tb.sv */
// Self-checking testbench for the 4x4 vector-matrix transform core.
// Streams vectors through random bursts and output stalls, reprogrammes the
// matrix between phases and checks every beat; depends only on vmt_pkg and the core.
module vector_matrix_transform_4x4_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import vmt_pkg::*;

    localparam int PIPE_LATENCY  = 4;
    localparam int WATCHDOG_MAX  = 2000;
    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_ITEMS   = 100;

    typedef logic [NUM_ROWS-1:0][ROW_W-1:0] row_set_t;

    typedef struct packed {
        logic sat;
        vec_t comp;
    } xform_result_t;

    typedef enum logic [1:0] {
        ITEM_VECTOR,
        ITEM_ROW_WRITE,
        ITEM_DRAIN
    } item_kind_t;

    typedef enum logic [1:0] {
        COEF_FULL,
        COEF_SMALL,
        COEF_EXTREME
    } coef_mode_t;

    typedef struct {
        item_kind_t          kind;
        vec_t                vec;
        logic [INDEX_W-1:0]  index;
        logic [ROW_W-1:0]    data;
    } beat_item_t;

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [127:0]       s_tdata  = '0;  // in_x, in_y, in_z, in_w
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [127:0]       m_tdata;        // out_x, out_y, out_z, out_w
    logic [0:0]         m_tuser;        // saturated
    logic               wr_en    = 1'b0;
    logic [INDEX_W-1:0] wr_index = '0;
    logic [ROW_W-1:0]   wr_data  = '0;

    beat_item_t    pending_beats[$];
    xform_result_t expected_results[$];
    row_set_t      coef_rows = {ROW_3_RESET, ROW_2_RESET, ROW_1_RESET, ROW_0_RESET};

    int error_count  = 0;
    int burst_left   = 8;
    int gap_left     = 0;
    int quiet_cycles = 0;
    int ready_mode   = 0;
    int ready_hold   = 0;
    int mode_cycles  = 0;
    int idle_cycles  = 0;

    vector_matrix_transform_4x4_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always #4 clk = ~clk;

    // Row vector times matrix; the arithmetic shift of the wide sum is a floor.
    function automatic xform_result_t transform_vertex(input vec_t vin, input row_set_t rows);
        xform_result_t res;
        longint        acc;
        res.sat = 1'b0;
        for (int c = 0; c < NUM_COLS; c++)
        begin
            acc = 0;
            for (int r = 0; r < NUM_ROWS; r++)
                acc += longint'($signed(vin[r])) *
                       longint'($signed(rows[r][COEF_W*c +: COEF_W]));
            acc = acc >>> FRAC_SHIFT;
            if (acc > longint'(32'sh7FFF_FFFF))
            begin
                res.comp[c] = SAT_MAX;
                res.sat     = 1'b1;
            end
            else if (acc < -longint'(64'h8000_0000))
            begin
                res.comp[c] = SAT_MIN;
                res.sat     = 1'b1;
            end
            else
                res.comp[c] = acc[COMP_W-1:0];
        end
        return res;
    endfunction

    function automatic vec_t make_vec(input logic [31:0] x, input logic [31:0] y,
                                      input logic [31:0] z, input logic [31:0] w);
        return {w, z, y, x};
    endfunction

    function automatic logic [31:0] rand_component();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            1:
            begin
                case ($urandom_range(0, 3))
                    0: return SAT_MAX;
                    1: return SAT_MIN;
                    2: return 32'h0;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] rand_coef(input coef_mode_t mode);
        logic [COEF_W-1:0] pick[5];
        pick = '{16'h7FFF, 16'h8000, 16'h0000, 16'h1000, 16'hF000};
        case (mode)
            COEF_SMALL:   return COEF_W'($urandom_range(0, 16'h2000) - 16'h1000);
            COEF_EXTREME: return pick[$urandom_range(0, 4)];
            default:      return COEF_W'($urandom);
        endcase
    endfunction

    task automatic add_vector(input vec_t v);
        beat_item_t item;
        item.kind  = ITEM_VECTOR;
        item.vec   = v;
        item.index = '0;
        item.data  = '0;
        pending_beats.push_back(item);
    endtask

    task automatic add_drain();
        beat_item_t item;
        item.kind  = ITEM_DRAIN;
        item.vec   = '0;
        item.index = '0;
        item.data  = '0;
        pending_beats.push_back(item);
    endtask

    task automatic add_matrix(input row_set_t rows);
        beat_item_t item;
        item.kind  = ITEM_ROW_WRITE;
        item.vec   = '0;
        item.index = REG_MATRIX_ROW_0;
        item.data  = rows[0];
        pending_beats.push_back(item);
        item.index = REG_MATRIX_ROW_1;
        item.data  = rows[1];
        pending_beats.push_back(item);
        item.index = REG_MATRIX_ROW_2;
        item.data  = rows[2];
        pending_beats.push_back(item);
        item.index = REG_MATRIX_ROW_3;
        item.data  = rows[3];
        pending_beats.push_back(item);
    endtask

    // Driver: vectors go out in bursts; matrix writes and drains wait for an empty pipe.
    always @(posedge clk or negedge rst_n)
    begin
        logic               next_valid;
        logic [127:0]       next_data;
        logic               next_wr;
        logic [INDEX_W-1:0] next_index;
        logic [ROW_W-1:0]   next_wdata;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            wr_en    <= 1'b0;
            wr_index <= '0;
            wr_data  <= '0;
        end
        else
        begin
            next_valid = s_tvalid;
            next_data  = s_tdata;
            next_wr    = 1'b0;
            next_index = wr_index;
            next_wdata = wr_data;
            if (s_tvalid && s_tready)
            begin
                expected_results.push_back(transform_vertex(s_tdata, coef_rows));
                void'(pending_beats.pop_front());
                next_valid = 1'b0;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    if ($urandom_range(0, 4) == 0)
                    begin
                        burst_left = $urandom_range(40, 80);
                        gap_left   = 0;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = $urandom_range(0, 6);
                    end
                end
            end
            if (expected_results.size() == 0 && !s_tvalid)
                quiet_cycles++;
            else
                quiet_cycles = 0;
            if (!next_valid && pending_beats.size() > 0)
            begin
                case (pending_beats[0].kind)
                    ITEM_VECTOR:
                    begin
                        if (gap_left > 0)
                            gap_left--;
                        else
                        begin
                            next_valid = 1'b1;
                            next_data  = pending_beats[0].vec;
                        end
                    end
                    ITEM_ROW_WRITE:
                    begin
                        if (quiet_cycles >= PIPE_LATENCY)
                        begin
                            next_wr    = 1'b1;
                            next_index = pending_beats[0].index;
                            next_wdata = pending_beats[0].data;
                            coef_rows[pending_beats[0].index] = pending_beats[0].data;
                            void'(pending_beats.pop_front());
                            // Keep the next vector clear of the edge that takes the write.
                            if (gap_left < 2)
                                gap_left = 2;
                        end
                    end
                    default:
                    begin
                        if (quiet_cycles >= PIPE_LATENCY)
                            void'(pending_beats.pop_front());
                    end
                endcase
            end
            s_tvalid <= next_valid;
            s_tdata  <= next_data;
            wr_en    <= next_wr;
            wr_index <= next_index;
            wr_data  <= next_wdata;
        end
    end

    // Monitor: checks each result beat and drives the output stall pattern.
    always @(posedge clk or negedge rst_n)
    begin
        xform_result_t want;
        logic          next_ready;
        string         comp_name[NUM_COLS];
        comp_name = '{"out_x", "out_y", "out_z", "out_w"};
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result beat with nothing expected: tdata %h", m_tdata);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    for (int c = 0; c < NUM_COLS; c++)
                        if (m_tdata[COMP_W*c +: COMP_W] !== want.comp[c])
                        begin
                            $error("%s mismatch: expected %h, actual %h", comp_name[c],
                                   want.comp[c], m_tdata[COMP_W*c +: COMP_W]);
                            error_count++;
                        end
                    if (m_tuser[0] !== want.sat)
                    begin
                        $error("saturated mismatch: expected %b, actual %b",
                               want.sat, m_tuser[0]);
                        error_count++;
                    end
                end
            end
            mode_cycles++;
            if (mode_cycles >= 256)
            begin
                mode_cycles = 0;
                ready_mode  = $urandom_range(0, 2);
            end
            next_ready = m_tready;
            case (ready_mode)
                0: next_ready = 1'b1;
                1: next_ready = ($urandom_range(0, 1) == 1);
                default:
                begin
                    if (ready_hold > 0)
                        ready_hold--;
                    else if (m_tready)
                    begin
                        next_ready = 1'b0;
                        ready_hold = $urandom_range(1, 12);
                    end
                    else
                    begin
                        next_ready = 1'b1;
                        ready_hold = $urandom_range(1, 8);
                    end
                end
            endcase
            m_tready <= next_ready;
        end
    end

    // Watchdog on cycles in which no beat and no write moves.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || wr_en)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_MAX)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        row_set_t   m;
        coef_mode_t mode;

        // Identity matrix from reset: extremes and the all-ones vector.
        add_vector(make_vec(32'h0, 32'h0, 32'h0, 32'h0));
        add_vector(make_vec(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX));
        add_vector(make_vec(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN));
        add_vector(make_vec(32'h1, 32'hFFFF_FFFF, 32'h1234_5678, 32'hFFFF_0000));
        add_vector(make_vec(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));

        // Largest positive coefficients: clamps high and low.
        add_matrix({4{64'h7FFF_7FFF_7FFF_7FFF}});
        add_vector(make_vec(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX));
        add_vector(make_vec(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN));
        add_vector(make_vec(SAT_MAX, SAT_MIN, SAT_MAX, SAT_MIN));
        add_vector(make_vec(32'h0, 32'h0, 32'h0, 32'h0));

        // Most negative coefficients: the minimum input clamps high.
        add_matrix({4{64'h8000_8000_8000_8000}});
        add_vector(make_vec(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN));
        add_vector(make_vec(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX));
        add_vector(make_vec(32'h1, 32'h1, 32'h1, 32'h1));

        // One-LSB coefficients: a tiny negative sum floors to minus one LSB.
        add_matrix({64'h0, 64'h0, 64'h0, 64'h0001_FFFF_0001_0001});
        add_vector(make_vec(32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0));
        add_vector(make_vec(32'h1, 32'h0, 32'h0, 32'h0));

        add_matrix('0);
        add_vector(make_vec($urandom, $urandom, $urandom, $urandom));

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            mode = coef_mode_t'(phase % 3);
            for (int r = 0; r < NUM_ROWS; r++)
                for (int c = 0; c < NUM_COLS; c++)
                    m[r][COEF_W*c +: COEF_W] = rand_coef(mode);
            if (phase == 3)
                m = {ROW_3_RESET, ROW_2_RESET, ROW_1_RESET, ROW_0_RESET};
            add_matrix(m);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                add_vector(make_vec(rand_component(), rand_component(),
                                    rand_component(), rand_component()));
                if (i == PHASE_ITEMS / 2 || $urandom_range(0, 149) == 0)
                    add_drain();
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_beats.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        repeat (4 * PIPE_LATENCY) @(posedge clk);

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* files.f */
+incdir+src
src/vmt_pkg.sv
src/vmt_lane.sv
src/vmt_merge.sv
src/vector_matrix_transform_4x4_core.sv
test/vector_matrix_transform_4x4_core_tb.sv
